// ----- sv/header_length_frame_receiver_unit_assert.svh -----
// Assertion macros for the header/length frame receiver.
`ifndef HEADER_LENGTH_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define HEADER_LENGTH_FRAME_RECEIVER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define HLFR_ASSERT(label, clk_sig, rst_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (prop)) \
    else $error(msg);

`define HLFR_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error(msg);

`else

`define HLFR_ASSERT(label, clk_sig, rst_sig, prop, msg)

`define HLFR_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg)

`endif

`endif

// ----- sv/hlfr_pkg.sv -----
// Package with the beat types and header constants of the frame receiver.
`default_nettype none

package hlfr_pkg;

  localparam logic [7:0] HDR_FIRST  = 8'h5A;
  localparam logic [7:0] HDR_SECOND = 8'hA5;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic [2:0] small_tail;
    logic [1:0] big_tail;
  } in_t;

  typedef struct packed {
    logic       store_valid;
    logic       target_big;
    logic [2:0] store_slot;
    logic [7:0] store_offset;
    logic [7:0] store_byte;
    logic       frame_done;
    logic       overflow;
    logic       small_ready;
    logic       big_ready;
  } out_t;

endpackage

`default_nettype wire

// ----- sv/header_length_frame_receiver_unit.sv -----
// Header/length frame receiver: one input beat per received byte, one result beat each.
//
// Input channel (in_valid/in_ready/in_data) carries a received byte plus the
// consumer read indices of the small and big frame queues. Every accepted beat
// produces exactly one result beat on the output channel (out_valid/out_ready/
// out_data): a write strobe into a queue slot, the frame-done and overflow
// flags, and the two queue status flags.
// The result of a beat is registered at the edge that accepts it and is offered
// in the following cycle. Throughput is one beat per cycle while out_ready is
// high; the limit is the single output register, which is refilled in the
// same cycle it is drained.
// When the receiver stalls, the result waits in the output register and
// in_ready drops until it is taken, so no beat is lost or repeated.
// Reset clears the header detector, the frame counters, both queue heads and
// status flags, and marks both queues as waiting for their first frame.
`default_nettype none
`include "header_length_frame_receiver_unit_assert.svh"

module header_length_frame_receiver_unit
  import hlfr_pkg::*;
#(
  parameter int SMALL_SLOTS = 8,
  parameter int BIG_SLOTS   = 4,
  parameter int SMALL_LIMIT = 10
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  localparam int SW     = (SMALL_SLOTS > 1) ? $clog2(SMALL_SLOTS) : 1;
  localparam int BW     = (BIG_SLOTS > 1) ? $clog2(BIG_SLOTS) : 1;
  localparam int SCMP_W = (SW > 3) ? SW : 3;
  localparam int BCMP_W = (BW > 2) ? BW : 2;
  localparam int SLOT_W = (SW > BW) ? ((SW > 3) ? SW : 3) : ((BW > 3) ? BW : 3);
  localparam logic [SW-1:0] SMALL_LAST = SW'(SMALL_SLOTS - 1);
  localparam logic [BW-1:0] BIG_LAST   = BW'(BIG_SLOTS - 1);
  localparam logic [8:0]    LIMIT      = 9'(SMALL_LIMIT);

  logic          seen_first_header, seen_first_header_next;
  logic          seen_second_header, seen_second_header_next;
  logic          receiving, receiving_next;
  logic [7:0]    bytes_left, bytes_left_next;
  logic          frame_is_big, frame_is_big_next;
  logic [7:0]    write_offset, write_offset_next;
  logic [SW-1:0] small_head, small_head_next;
  logic [BW-1:0] big_head, big_head_next;
  logic          small_first_pending, small_first_pending_next;
  logic          big_first_pending, big_first_pending_next;
  logic          small_status, small_status_next;
  logic          big_status, big_status_next;

  logic          accept;
  out_t          result;
  logic [SW-1:0] small_adv;
  logic [BW-1:0] big_adv;
  logic [7:0]    left1;
  logic [SLOT_W-1:0] slot_wide;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign small_adv = (small_head == SMALL_LAST) ? '0 : small_head + 1'b1;
  assign big_adv   = (big_head == BIG_LAST) ? '0 : big_head + 1'b1;

  always_comb begin
    seen_first_header_next   = (in_data.rx_byte == HDR_FIRST);
    seen_second_header_next  = seen_first_header && (in_data.rx_byte == HDR_SECOND);
    receiving_next           = receiving;
    frame_is_big_next        = frame_is_big;
    write_offset_next        = write_offset;
    small_head_next          = small_head;
    big_head_next            = big_head;
    small_first_pending_next = small_first_pending;
    big_first_pending_next   = big_first_pending;
    small_status_next        = small_status;
    big_status_next          = big_status;
    left1                    = bytes_left;
    result                   = '0;

    // The byte after a complete header is the length byte and opens a frame.
    if (seen_second_header) begin
      receiving_next    = 1'b1;
      left1             = in_data.rx_byte + 8'd1;
      write_offset_next = '0;
      if ({1'b0, left1} < LIMIT) begin
        frame_is_big_next = 1'b0;
        small_status_next = 1'b0;
        if (small_first_pending) begin
          small_first_pending_next = 1'b0;
        end else if (SCMP_W'(small_adv) != SCMP_W'(in_data.small_tail)) begin
          small_head_next = small_adv;
        end else begin
          result.overflow = 1'b1;
        end
      end else begin
        frame_is_big_next = 1'b1;
        big_status_next   = 1'b0;
        if (big_first_pending) begin
          big_first_pending_next = 1'b0;
        end else if (BCMP_W'(big_adv) != BCMP_W'(in_data.big_tail)) begin
          big_head_next = big_adv;
        end else begin
          result.overflow = 1'b1;
        end
      end
    end

    bytes_left_next = left1;
    slot_wide = frame_is_big_next ? SLOT_W'(big_head_next) : SLOT_W'(small_head_next);

    if (receiving_next) begin
      if (left1 != 8'd0) begin
        result.store_valid  = 1'b1;
        result.store_slot   = slot_wide[2:0];
        result.store_offset = write_offset_next;
        result.store_byte   = in_data.rx_byte;
        write_offset_next   = write_offset_next + 8'd1;
        bytes_left_next     = left1 - 8'd1;
      end
      if (bytes_left_next == 8'd0) begin
        receiving_next    = 1'b0;
        result.frame_done = 1'b1;
        if (frame_is_big_next) begin
          big_status_next = 1'b1;
        end else begin
          small_status_next = 1'b1;
        end
      end
    end

    result.target_big  = frame_is_big_next;
    result.small_ready = small_status_next;
    result.big_ready   = big_status_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_first_header   <= 1'b0;
      seen_second_header  <= 1'b0;
      receiving           <= 1'b0;
      bytes_left          <= '0;
      frame_is_big        <= 1'b0;
      write_offset        <= '0;
      small_head          <= '0;
      big_head            <= '0;
      small_first_pending <= 1'b1;
      big_first_pending   <= 1'b1;
      small_status        <= 1'b0;
      big_status          <= 1'b0;
    end else if (accept) begin
      seen_first_header   <= seen_first_header_next;
      seen_second_header  <= seen_second_header_next;
      receiving           <= receiving_next;
      bytes_left          <= bytes_left_next;
      frame_is_big        <= frame_is_big_next;
      write_offset        <= write_offset_next;
      small_head          <= small_head_next;
      big_head            <= big_head_next;
      small_first_pending <= small_first_pending_next;
      big_first_pending   <= big_first_pending_next;
      small_status        <= small_status_next;
      big_status          <= big_status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

  `HLFR_ASSERT(a_idle_no_count, clk, rst, !receiving |-> (bytes_left == 8'd0), "count left while idle")
  `HLFR_ASSERT(a_small_first_head, clk, rst, small_first_pending |-> (small_head == '0), "small head moved before first frame")
  `HLFR_ASSERT(a_big_first_head, clk, rst, big_first_pending |-> (big_head == '0), "big head moved before first frame")
  `HLFR_ASSERT(a_header_exclusive, clk, rst, !(seen_first_header && seen_second_header), "both header stages set")
  `HLFR_ASSERT_NEXT(a_accept_result, clk, rst, accept, out_valid, "accepted beat gave no result")

endmodule

`default_nettype wire

// ----- verif/header_length_frame_receiver_unit_test.sv -----
// Self-checking testbench for the header/length frame receiver.
module header_length_frame_receiver_unit_test;
  import hlfr_pkg::*;

  localparam int RANDOM_ITEMS = 1950;
  localparam int SMALL_LIMIT  = 10;
  localparam out_t NO_STORE   = '0;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  out_t expected_stores[$];

  // Predictor state, mirroring the block after reset.
  logic       hdr_lead_seen = 1'b0;
  logic       hdr_pair_seen = 1'b0;
  logic       in_frame = 1'b0;
  logic [7:0] frame_left = 8'd0;
  logic       frame_big = 1'b0;
  logic [7:0] frame_pos = 8'd0;
  logic [2:0] sq_head = 3'd0;
  logic [1:0] bq_head = 2'd0;
  logic       sq_fresh = 1'b1;
  logic       bq_fresh = 1'b1;
  logic       sq_done = 1'b0;
  logic       bq_done = 1'b0;

  typedef struct {
    in_t  beat;
    bit   typed;
    out_t want;
  } step_row_t;

  // Rows marked typed carry a result that is known by inspection; the others
  // are checked against the predictor.
  step_row_t directed_rows[24] = '{
    '{'{8'h00, 3'd0, 2'd0}, 1'b1, NO_STORE},
    '{'{8'hFF, 3'd7, 2'd3}, 1'b1, NO_STORE},
    '{'{8'h5A, 3'd0, 2'd0}, 1'b1, NO_STORE},
    '{'{8'hA5, 3'd0, 2'd0}, 1'b1, NO_STORE},
    // Length FF wraps to an empty frame that completes at once.
    '{'{8'hFF, 3'd0, 2'd0}, 1'b1,
      '{1'b0, 1'b0, 3'd0, 8'h00, 8'h00, 1'b1, 1'b0, 1'b1, 1'b0}},
    '{'{8'h5A, 3'd2, 2'd1}, 1'b0, NO_STORE},
    '{'{8'hA5, 3'd0, 2'd0}, 1'b0, NO_STORE},
    // Small queue full: the slot is reused and overflow is raised.
    '{'{8'h01, 3'd1, 2'd0}, 1'b1,
      '{1'b1, 1'b0, 3'd0, 8'h00, 8'h01, 1'b0, 1'b1, 1'b0, 1'b0}},
    '{'{8'h33, 3'd5, 2'd2}, 1'b0, NO_STORE},
    '{'{8'h5A, 3'd0, 2'd0}, 1'b0, NO_STORE},
    '{'{8'hA5, 3'd0, 2'd0}, 1'b0, NO_STORE},
    '{'{8'h09, 3'd0, 2'd0}, 1'b0, NO_STORE},
    // A header inside the payload restarts reception.
    '{'{8'h5A, 3'd0, 2'd0}, 1'b0, NO_STORE},
    '{'{8'hA5, 3'd0, 2'd0}, 1'b0, NO_STORE},
    '{'{8'h00, 3'd0, 2'd1}, 1'b0, NO_STORE},
    '{'{8'h5A, 3'd0, 2'd0}, 1'b0, NO_STORE},
    '{'{8'hA5, 3'd0, 2'd0}, 1'b0, NO_STORE},
    // Big queue full on the longest frame.
    '{'{8'hFE, 3'd0, 2'd1}, 1'b1,
      '{1'b1, 1'b1, 3'd0, 8'h00, 8'hFE, 1'b0, 1'b1, 1'b1, 1'b0}},
    '{'{8'hC3, 3'd4, 2'd3}, 1'b0, NO_STORE},
    '{'{8'h5A, 3'd0, 2'd0}, 1'b0, NO_STORE},
    '{'{8'hA5, 3'd0, 2'd0}, 1'b0, NO_STORE},
    '{'{8'h08, 3'd6, 2'd2}, 1'b0, NO_STORE},
    '{'{8'hFF, 3'd0, 2'd0}, 1'b0, NO_STORE},
    '{'{8'h00, 3'd3, 2'd1}, 1'b0, NO_STORE}
  };

  header_length_frame_receiver_unit dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Works out the store strobe and flags that one received byte causes.
  function automatic out_t frame_store_for(in_t beat);
    out_t res;
    logic [2:0] sq_next;
    logic [1:0] bq_next;
    res = '0;
    sq_next = sq_head + 3'd1;
    bq_next = bq_head + 2'd1;
    if (hdr_pair_seen) begin
      in_frame = 1'b1;
      frame_left = beat.rx_byte + 8'd1;
      frame_pos = 8'd0;
      hdr_pair_seen = 1'b0;
      frame_big = (frame_left >= 8'(SMALL_LIMIT));
      if (!frame_big) begin
        if (sq_fresh) begin
          sq_fresh = 1'b0;
        end else if (sq_next != beat.small_tail) begin
          sq_head = sq_next;
        end else begin
          res.overflow = 1'b1;
        end
        sq_done = 1'b0;
      end else begin
        if (bq_fresh) begin
          bq_fresh = 1'b0;
        end else if (bq_next != beat.big_tail) begin
          bq_head = bq_next;
        end else begin
          res.overflow = 1'b1;
        end
        bq_done = 1'b0;
      end
    end
    if (hdr_lead_seen) begin
      if (beat.rx_byte == HDR_SECOND) hdr_pair_seen = 1'b1;
      hdr_lead_seen = 1'b0;
    end
    if (beat.rx_byte == HDR_FIRST) hdr_lead_seen = 1'b1;
    if (in_frame) begin
      if (frame_left != 8'd0) begin
        res.store_valid = 1'b1;
        res.store_slot = frame_big ? {1'b0, bq_head} : sq_head;
        res.store_offset = frame_pos;
        res.store_byte = beat.rx_byte;
        frame_pos = frame_pos + 8'd1;
        frame_left = frame_left - 8'd1;
      end
      if (frame_left == 8'd0) begin
        in_frame = 1'b0;
        res.frame_done = 1'b1;
        if (frame_big) bq_done = 1'b1;
        else sq_done = 1'b1;
      end
    end
    res.target_big = frame_big;
    res.small_ready = sq_done;
    res.big_ready = bq_done;
    return res;
  endfunction

  function automatic in_t random_beat();
    in_t b;
    b.rx_byte = 8'($urandom_range(255));
    b.small_tail = 3'($urandom_range(7));
    b.big_tail = 2'($urandom_range(3));
    return b;
  endfunction

  // Mostly well-formed frames with random content; the rest is line noise,
  // broken headers and frames cut short by the next header.
  function automatic void plan_burst(ref in_t burst[$]);
    int unsigned kind;
    int unsigned pick;
    int unsigned count;
    in_t b;
    burst.delete();
    kind = $urandom_range(99);
    if (kind < 15) begin
      repeat ($urandom_range(4, 1)) burst.push_back(random_beat());
    end else if (kind < 25) begin
      b = random_beat();
      b.rx_byte = HDR_FIRST;
      burst.push_back(b);
      b = random_beat();
      if (b.rx_byte == HDR_SECOND) b.rx_byte = HDR_FIRST;
      burst.push_back(b);
    end else begin
      b = random_beat();
      b.rx_byte = HDR_FIRST;
      burst.push_back(b);
      b = random_beat();
      b.rx_byte = HDR_SECOND;
      burst.push_back(b);
      pick = $urandom_range(99);
      b = random_beat();
      if (pick < 85) b.rx_byte = 8'($urandom_range(20));
      else if (pick < 98) b.rx_byte = 8'($urandom_range(60, 21));
      else b.rx_byte = 8'($urandom_range(255, 200));
      // Aim the tails at the slot after the head so full queues come up often.
      if ($urandom_range(2) == 0) begin
        b.small_tail = sq_head + 3'd1;
        b.big_tail = bq_head + 2'd1;
      end
      burst.push_back(b);
      count = (int'(b.rx_byte) + 1) % 256;
      if (kind >= 90 && count > 1) count = $urandom_range(count - 1, 1);
      for (int i = 1; i < int'(count); i++) burst.push_back(random_beat());
    end
  endfunction

  task automatic send_beat(in_t beat, bit typed, out_t want);
    out_t guess;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    guess = frame_store_for(beat);
    expected_stores.push_back(typed ? want : guess);
  endtask

  task automatic report_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %h got %h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : check_stores
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_stores.size() == 0) begin
        errors++;
        $display("%0t: result beat %h with none expected", $time, out_data);
      end else begin
        want = expected_stores.pop_front();
        report_field("store_valid", 8'(want.store_valid), 8'(out_data.store_valid));
        report_field("target_big", 8'(want.target_big), 8'(out_data.target_big));
        report_field("store_slot", 8'(want.store_slot), 8'(out_data.store_slot));
        report_field("store_offset", want.store_offset, out_data.store_offset);
        report_field("store_byte", want.store_byte, out_data.store_byte);
        report_field("frame_done", 8'(want.frame_done), 8'(out_data.frame_done));
        report_field("overflow", 8'(want.overflow), 8'(out_data.overflow));
        report_field("small_ready", 8'(want.small_ready), 8'(out_data.small_ready));
        report_field("big_ready", 8'(want.big_ready), 8'(out_data.big_ready));
      end
    end
  end

  initial begin : stimulus
    in_t burst[$];
    int unsigned random_sent;
    int unsigned phase_now;
    int unsigned phase_was;
    random_sent = 0;
    phase_was = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i]) begin
      send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);
    end
    while (random_sent < RANDOM_ITEMS) begin
      phase_now = random_sent * 4 / RANDOM_ITEMS;
      if (phase_now != phase_was) begin
        // Hold the sender off until every outstanding beat has come back.
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_stores.size() != 0) @(posedge clk);
        phase_was = phase_now;
        case (phase_now)
          1: begin
            send_idle_pct = 51;
            recv_stall_pct = 0;
          end
          2: begin
            send_idle_pct = 0;
            recv_stall_pct = 51;
          end
          default: begin
            send_idle_pct = 6;
            recv_stall_pct = 6;
          end
        endcase
      end
      plan_burst(burst);
      foreach (burst[i]) send_beat(burst[i], 1'b0, NO_STORE);
      random_sent += burst.size();
    end
    in_valid <= 1'b0;
    while (expected_stores.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
